/* design/nlpd_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest line point distance package
// Shared types, command codes and sizing constants for the distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package nlpd_pkg;

   // Point list sizing.
   localparam int MAX_POINTS = 16384;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Field widths.
   localparam int X_W    = 10;
   localparam int Y_W    = 9;
   localparam int DX2_W  = 2 * X_W;
   localparam int DY2_W  = 2 * Y_W;
   localparam int D2_W   = DX2_W + 1;
   localparam int DIST_W = 10;

   // Square root unit: radicand padded to an even width.
   localparam int SQ_W   = D2_W + (D2_W % 2);
   localparam int ROOT_W = SQ_W / 2;
   localparam logic [SQ_W-1:0] SQRT_TOP = SQ_W'(1) << (SQ_W - 2);
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Command queue between the front and the back.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Command codes.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]     cmd;
      logic [X_W-1:0] point_x;
      logic [Y_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [X_W-1:0]    nearest_x;
      logic [Y_W-1:0]    nearest_y;
      logic              no_points;
   } rsp_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      req_type item;
   } cmd_head_type;

   // Square root unit request and status.
   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] operand;
   } sqrt_req_type;

   typedef struct packed {
      logic              busy;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_SQRT
   } eng_state_type;

endpackage

`default_nettype wire

/* design/nlpd_front.sv */
// ----------------------------------------------------------------------------
// Nearest line point distance front end
// Accepts request beats, drops unused command codes and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module nlpd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire nlpd_pkg::req_type     req_data,
   output nlpd_pkg::cmd_head_type     head,
   input  wire logic                  head_pop
);
   import nlpd_pkg::*;

   req_type           queue_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              accept;
   logic              store;
   logic              take;

   // A beat is taken whenever there is room; unused codes are not stored.
   assign full   = (cnt_ff == QCNT_W'(QDEPTH));
   assign accept = push && !full;
   assign store  = accept && (req_data.cmd != CMD_NONE);
   assign take   = head_pop && (cnt_ff != '0);

   assign head.valid = (cnt_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = store ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (store && !take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (take && !store) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (store) begin
         queue_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

`default_nettype wire

/* design/nlpd_sqrt.sv */
// ----------------------------------------------------------------------------
// Nearest line point distance square root unit
// Bit-pair iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nlpd_sqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nlpd_pkg::sqrt_req_type sq_req,
   output nlpd_pkg::sqrt_rsp_type     sq_rsp
);
   import nlpd_pkg::*;

   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W-1:0] trial;

   assign trial = root_ff + bit_ff;

   // One iteration per cycle until the probe bit shifts out.
   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (sq_req.start) begin
         rem_in  = sq_req.operand;
         root_in = '0;
         bit_in  = SQRT_TOP;
      end else if (bit_ff != '0) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sq_rsp.busy = (bit_ff != '0);
   assign sq_rsp.root = root_ff[ROOT_W-1:0];

endmodule

`default_nettype wire

/* design/nlpd_engine.sv */
// ----------------------------------------------------------------------------
// Nearest line point distance back end
// Holds the point list, scans it for the nearest point and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module nlpd_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nlpd_pkg::cmd_head_type head,
   output logic                       head_pop,
   output logic                       empty,
   input  wire logic                  pop,
   output nlpd_pkg::rsp_type          rsp_data
);
   import nlpd_pkg::*;

   eng_state_type state_ff, state_in;

   // Point list and its fill count.
   logic [X_W+Y_W-1:0] store_mem [MAX_POINTS];
   logic [CNT_W-1:0]   count_ff, count_in;

   // Scan pipeline.
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               rd_valid_ff, sq_valid_ff, first_ff;
   logic [X_W+Y_W-1:0] rd_data_ff;
   logic [X_W-1:0]     qx_ff, sq_x_ff, best_x_ff;
   logic [Y_W-1:0]     qy_ff, sq_y_ff, best_y_ff;
   logic [DX2_W-1:0]   dx2_ff;
   logic [DY2_W-1:0]   dy2_ff;
   logic [D2_W-1:0]    best_d2_ff;
   logic [X_W-1:0]     rd_x, dx;
   logic [Y_W-1:0]     rd_y, dy;
   logic [D2_W-1:0]    d2_sum;
   logic               issuing, scan_done, better;

   // Result register.
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_free;

   // Control strobes.
   logic               wr_en, cnt_inc, cnt_clr, scan_start;
   logic               empty_rsp, final_rsp;
   logic [DIST_W-1:0]  dist_sat;

   sqrt_req_type       sq_req;
   sqrt_rsp_type       sq_rsp;

   nlpd_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   assign rsp_free  = !rsp_valid_ff || pop;
   assign issuing   = (state_ff == ENG_SCAN) && (issue_ff < count_ff);
   assign scan_done = (state_ff == ENG_SCAN) && !issuing && !rd_valid_ff && !sq_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (head.valid && (head.item.cmd == CMD_QUERY) && (count_ff != '0)) begin
               state_in = ENG_SCAN;
            end
         end
         ENG_SCAN: begin
            if (scan_done) begin
               state_in = ENG_SQRT;
            end
         end
         ENG_SQRT: begin
            if (!sq_rsp.busy && rsp_free) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // Control outputs per state.
   always_comb begin
      head_pop   = 1'b0;
      wr_en      = 1'b0;
      cnt_inc    = 1'b0;
      cnt_clr    = 1'b0;
      scan_start = 1'b0;
      empty_rsp  = 1'b0;
      final_rsp  = 1'b0;
      sq_req.start   = 1'b0;
      sq_req.operand = SQ_W'(best_d2_ff);
      case (state_ff)
         ENG_IDLE: begin
            if (head.valid) begin
               case (head.item.cmd)
                  CMD_ADD: begin
                     head_pop = 1'b1;
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        wr_en   = 1'b1;
                        cnt_inc = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     head_pop = 1'b1;
                     cnt_clr  = 1'b1;
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        if (rsp_free) begin
                           empty_rsp = 1'b1;
                           head_pop  = 1'b1;
                        end
                     end else begin
                        scan_start = 1'b1;
                        head_pop   = 1'b1;
                     end
                  end
                  default: head_pop = 1'b1;
               endcase
            end
         end
         ENG_SCAN: begin
            sq_req.start = scan_done;
         end
         ENG_SQRT: begin
            final_rsp = !sq_rsp.busy && rsp_free;
         end
         default: begin
            head_pop = 1'b0;
         end
      endcase
   end

   // Fill count and scan index.
   always_comb begin
      count_in = count_ff;
      if (cnt_clr) begin
         count_in = '0;
      end else if (cnt_inc) begin
         count_in = count_ff + 1'b1;
      end
      issue_in = issue_ff;
      if (scan_start) begin
         issue_in = '0;
      end else if (issuing) begin
         issue_in = issue_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= issuing;
         sq_valid_ff <= rd_valid_ff;
         if (empty_rsp || final_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Point memory: one write port for adds, one registered read for scans.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[ADDR_W-1:0]] <= {head.item.point_x, head.item.point_y};
      end
      rd_data_ff <= store_mem[issue_ff[ADDR_W-1:0]];
   end

   // Absolute differences from the query pixel.
   assign rd_x = rd_data_ff[X_W+Y_W-1:Y_W];
   assign rd_y = rd_data_ff[Y_W-1:0];
   assign dx   = (qx_ff >= rd_x) ? (qx_ff - rd_x) : (rd_x - qx_ff);
   assign dy   = (qy_ff >= rd_y) ? (qy_ff - rd_y) : (rd_y - qy_ff);

   // Squared distance and strict-less compare keep the earliest on ties.
   assign d2_sum = D2_W'(dx2_ff) + D2_W'(dy2_ff);
   assign better = first_ff || (d2_sum < best_d2_ff);

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      if (scan_start) begin
         qx_ff    <= head.item.point_x;
         qy_ff    <= head.item.point_y;
         first_ff <= 1'b1;
      end else if (sq_valid_ff) begin
         first_ff <= 1'b0;
      end
      dx2_ff  <= DX2_W'(dx * dx);
      dy2_ff  <= DY2_W'(dy * dy);
      sq_x_ff <= rd_x;
      sq_y_ff <= rd_y;
      if (sq_valid_ff && better) begin
         best_d2_ff <= d2_sum;
         best_x_ff  <= sq_x_ff;
         best_y_ff  <= sq_y_ff;
      end
   end

   // Result assembly with saturation of the root.
   assign dist_sat = (sq_rsp.root > ROOT_W'(DIST_MAX)) ? DIST_MAX
                                                       : sq_rsp.root[DIST_W-1:0];

   always_comb begin
      rsp_in = rsp_ff;
      if (empty_rsp) begin
         rsp_in.distance  = '0;
         rsp_in.nearest_x = '0;
         rsp_in.nearest_y = '0;
         rsp_in.no_points = 1'b1;
      end else if (final_rsp) begin
         rsp_in.distance  = dist_sat;
         rsp_in.nearest_x = best_x_ff;
         rsp_in.nearest_y = best_y_ff;
         rsp_in.no_points = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* design/nearest_line_point_distance_top.sv */
// A query with stored points occupies the back end through its scan and
// the square root, and holds it until its result register is free; the
// single read port of the point memory scans one point per cycle. Adds
// and clears retire without a scan. Reset is synchronous and empties the
// point list, the command queue and the result register at once.
// ----------------------------------------------------------------------------
// Nearest line point distance top level
// Front end command queue feeding the point list scan and square root back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_line_point_distance_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire nlpd_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output nlpd_pkg::rsp_type      rsp_data
);
   import nlpd_pkg::*;

   cmd_head_type head;
   logic         head_pop;

   // Front end: accept and queue command beats.
   nlpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .head     (head),
      .head_pop (head_pop)
   );

   // Back end: point list, scan and result register.
   nlpd_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

/* design/nlpd_checker.sv */
// ----------------------------------------------------------------------------
// Nearest line point distance port checker
// Watches the top level ports for reset state and result beat consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module nlpd_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              full,
   input  wire logic              empty,
   input  wire logic              pop,
   input  wire nlpd_pkg::rsp_type rsp_data
);
   import nlpd_pkg::*;

   // After reset the command queue has room.
   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("queue full after reset");

   // After reset no result is waiting.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result waiting after reset");

   // A waiting result beat holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result beat changed before pop");

   // An empty list result carries zero in every other field.
   a_no_points_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.no_points) |->
      (rsp_data.distance == '0 && rsp_data.nearest_x == '0 &&
       rsp_data.nearest_y == '0))
      else $error("empty list result has nonzero fields");

endmodule

bind nearest_line_point_distance_top nlpd_checker u_checker (.*);

`default_nettype wire
